@@ rtl/lrufr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrufr_pkg;

    // Frame id and count widths
    localparam int ID_W      = 6;
    localparam int FRAME_IDS = 64;
    localparam int CNT_W     = 7;

    // Operation codes on the request channel
    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2
    } op_t;

endpackage

`default_nettype wire

@@ rtl/lrufr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat
interface lrufr_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [lrufr_pkg::ID_W-1:0]    frame;

    modport source (output valid, output op, output frame, input ready);
    modport sink   (input valid, input op, input frame, output ready);
endinterface

// Response channel: one result per beat
interface lrufr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [lrufr_pkg::ID_W-1:0]    victim_frame;
    logic [lrufr_pkg::CNT_W-1:0]   held_count;

    modport source (output valid, output found, output victim_frame, output held_count,
                    input ready);
    modport sink   (input valid, input found, input victim_frame, input held_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/lrufr_link_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One link table: one write port, one read port, registered read data
module lrufr_link_ram (
    input  wire                           clk,
    input  wire                           wr_en,
    input  wire [lrufr_pkg::ID_W-1:0]     wr_addr,
    input  wire [lrufr_pkg::ID_W-1:0]     wr_data,
    input  wire                           rd_en,
    input  wire [lrufr_pkg::ID_W-1:0]     rd_addr,
    output logic [lrufr_pkg::ID_W-1:0]    rd_data
);

    logic [lrufr_pkg::ID_W-1:0] mem [lrufr_pkg::FRAME_IDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lru_frame_replacer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------
// req      in   op (victim / pin / unpin), frame
// rsp      out  found, victim_frame, held_count
//
// Each operation passes through accept, link table read, then update and
// result load. The registered read of the link tables needs its own step.
// Reset (rst_n low, asynchronous) clears the presence bits, head, tail, count
// and the result valid; link tables hold no reset value.
// A stalled rsp holds the update step; a new req is accepted while a result
// waits, once the previous operation has been written back.
module lru_frame_replacer #(
    parameter int unsigned FRAMES = 64
) (
    input  wire          clk,
    input  wire          rst_n,
    lrufr_req_if.sink    req,
    lrufr_rsp_if.source  rsp
);

    localparam int ID_W  = lrufr_pkg::ID_W;
    localparam int CNT_W = lrufr_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_WR   = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_UNLINK = 2'd1,
        ACT_LINK   = 2'd2
    } act_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      op_reg;
    logic [ID_W-1:0]                 frame_reg;
    logic [ID_W-1:0]                 tgt_reg, tgt_next;
    act_t                            act_reg, act_next;
    logic [lrufr_pkg::FRAME_IDS-1:0] present_reg, present_next;
    logic [ID_W-1:0]                 newest_reg, newest_next;
    logic [ID_W-1:0]                 oldest_reg, oldest_next;
    logic [CNT_W-1:0]                count_reg, count_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            found_reg, found_next;
    logic [ID_W-1:0]                 victim_reg, victim_next;
    logic [CNT_W-1:0]                held_reg, held_next;

    logic                            req_fire;
    logic                            wr_fire;
    logic                            rd_en;
    logic [ID_W-1:0]                 older;
    logic [ID_W-1:0]                 newer;
    logic                            nl_wr_en, pl_wr_en;
    logic [ID_W-1:0]                 nl_wr_addr, nl_wr_data;
    logic [ID_W-1:0]                 pl_wr_addr, pl_wr_data;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign wr_fire   = (state_reg == ST_WR) && (!out_valid_reg || rsp.ready);
    assign rd_en     = (state_reg == ST_RD);

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = found_reg;
    assign rsp.victim_frame = victim_reg;
    assign rsp.held_count   = held_reg;

    // Link tables: next_link points older, prev_link points newer
    lrufr_link_ram u_next_link (
        .clk     (clk),
        .wr_en   (nl_wr_en),
        .wr_addr (nl_wr_addr),
        .wr_data (nl_wr_data),
        .rd_en   (rd_en),
        .rd_addr (tgt_next),
        .rd_data (older)
    );

    lrufr_link_ram u_prev_link (
        .clk     (clk),
        .wr_en   (pl_wr_en),
        .wr_addr (pl_wr_addr),
        .wr_data (pl_wr_data),
        .rd_en   (rd_en),
        .rd_addr (tgt_next),
        .rd_data (newer)
    );

    // Decide the action and target from the current list state
    always_comb
    begin
        tgt_next = tgt_reg;
        act_next = act_reg;
        if (state_reg == ST_RD)
        begin
            tgt_next = frame_reg;
            act_next = ACT_NONE;
            case (op_reg)
                lrufr_pkg::OP_VICTIM:
                begin
                    tgt_next = oldest_reg;
                    if (count_reg != '0)
                    begin
                        act_next = ACT_UNLINK;
                    end
                end
                lrufr_pkg::OP_PIN:
                begin
                    if (present_reg[frame_reg])
                    begin
                        act_next = ACT_UNLINK;
                    end
                end
                lrufr_pkg::OP_UNPIN:
                begin
                    if (!present_reg[frame_reg] && (32'(count_reg) < FRAMES))
                    begin
                        act_next = ACT_LINK;
                    end
                end
                default:
                begin
                    act_next = ACT_NONE;
                end
            endcase
        end
    end

    // Update step: link writes, head/tail/count, result
    always_comb
    begin
        present_next = present_reg;
        newest_next  = newest_reg;
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        nl_wr_en     = 1'b0;
        nl_wr_addr   = newer;
        nl_wr_data   = older;
        pl_wr_en     = 1'b0;
        pl_wr_addr   = older;
        pl_wr_data   = newer;
        found_next   = found_reg;
        victim_next  = victim_reg;
        held_next    = held_reg;

        if (wr_fire)
        begin
            case (act_reg)
                ACT_UNLINK:
                begin
                    if (count_reg <= CNT_W'(1))
                    begin
                        newest_next = '0;
                        oldest_next = '0;
                    end
                    else
                    begin
                        if (tgt_reg == newest_reg)
                        begin
                            newest_next = older;
                        end
                        else
                        begin
                            nl_wr_en = 1'b1;
                        end
                        if (tgt_reg == oldest_reg)
                        begin
                            oldest_next = newer;
                        end
                        else
                        begin
                            pl_wr_en = 1'b1;
                        end
                    end
                    present_next[tgt_reg] = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
                ACT_LINK:
                begin
                    if (count_reg == '0)
                    begin
                        newest_next = tgt_reg;
                        oldest_next = tgt_reg;
                    end
                    else
                    begin
                        nl_wr_en    = 1'b1;
                        nl_wr_addr  = tgt_reg;
                        nl_wr_data  = newest_reg;
                        pl_wr_en    = 1'b1;
                        pl_wr_addr  = newest_reg;
                        pl_wr_data  = tgt_reg;
                        newest_next = tgt_reg;
                    end
                    present_next[tgt_reg] = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase

            found_next  = (op_reg == lrufr_pkg::OP_VICTIM) && (act_reg == ACT_UNLINK);
            victim_next = found_next ? tgt_reg : '0;
            held_next   = count_next;
        end
    end

    // Sequencer and result valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (wr_fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            newest_reg    <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            newest_reg    <= newest_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req.op;
            frame_reg <= req.frame;
        end
        tgt_reg    <= tgt_next;
        act_reg    <= act_next;
        found_reg  <= found_next;
        victim_reg <= victim_next;
        held_reg   <= held_next;
    end

endmodule

`default_nettype wire

@@ test/lru_frame_replacer_test.sv @@
`timescale 1ns / 1ps

module lru_frame_replacer_test;

    localparam int          ID_W        = lrufr_pkg::ID_W;
    localparam int          CNT_W       = lrufr_pkg::CNT_W;
    localparam int          FRAME_IDS   = lrufr_pkg::FRAME_IDS;
    localparam int          PHASE_ITEMS = 375;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    // One result beat
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   victim_frame;
        logic [CNT_W-1:0]  held_count;
    } rsp_beat_t;

    // Directed stimulus row; typed rows carry their own expected beat
    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  frame;
        logic             typed;
        rsp_beat_t        beat;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TBL [0:DIR_ROWS-1] = '{
        '{lrufr_pkg::OP_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},  // empty tracker
        '{lrufr_pkg::OP_VICTIM, 6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},  // frame ignored
        '{lrufr_pkg::OP_PIN,    6'd5,  1'b1, '{1'b0, 6'd0,  7'd0}},  // pin, not held
        '{OP_UNUSED,            6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{OP_UNUSED,            6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},
        '{lrufr_pkg::OP_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd1}},
        '{lrufr_pkg::OP_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{lrufr_pkg::OP_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},  // held, keeps place
        '{lrufr_pkg::OP_UNPIN,  6'd42, 1'b1, '{1'b0, 6'd0,  7'd3}},
        '{lrufr_pkg::OP_PIN,    6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},  // pin from middle
        '{OP_UNUSED,            6'd21, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{lrufr_pkg::OP_VICTIM, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd1}},
        '{lrufr_pkg::OP_VICTIM, 6'd0,  1'b1, '{1'b1, 6'd42, 7'd0}},
        '{lrufr_pkg::OP_UNPIN,  6'd10, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{lrufr_pkg::OP_PIN,    6'd10, 1'b1, '{1'b0, 6'd0,  7'd0}},  // pin, only frame
        '{lrufr_pkg::OP_PIN,    6'd10, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{lrufr_pkg::OP_UNPIN,  6'd1,  1'b0, '0},
        '{lrufr_pkg::OP_UNPIN,  6'd2,  1'b0, '0},
        '{lrufr_pkg::OP_UNPIN,  6'd3,  1'b0, '0},
        '{lrufr_pkg::OP_PIN,    6'd3,  1'b0, '0},                    // pin of the newest
        '{lrufr_pkg::OP_PIN,    6'd1,  1'b0, '0},                    // pin of the oldest
        '{lrufr_pkg::OP_UNPIN,  6'd1,  1'b0, '0},
        '{lrufr_pkg::OP_VICTIM, 6'd0,  1'b0, '0},
        '{lrufr_pkg::OP_VICTIM, 6'd0,  1'b0, '0},
        '{lrufr_pkg::OP_VICTIM, 6'd9,  1'b1, '{1'b0, 6'd0,  7'd0}}
    };

    logic clk;
    logic rst_n;

    lrufr_req_if req ();
    lrufr_rsp_if rsp ();

    lru_frame_replacer #(
        .FRAMES (FRAME_IDS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Tracker model state
    logic [ID_W-1:0]  older_of [FRAME_IDS];
    logic [ID_W-1:0]  newer_of [FRAME_IDS];
    logic             is_held  [FRAME_IDS];
    logic [ID_W-1:0]  newest_frame;
    logic [ID_W-1:0]  oldest_frame;
    int unsigned      held_total;

    rsp_beat_t        pending_rsp [$];
    int               err_cnt   = 0;
    int               cycle_cnt = 0;
    int               send_idle_pct;
    int               rsp_stall_pct;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drop a held frame from the order
    function automatic void drop_frame(input logic [ID_W-1:0] f);
        logic [ID_W-1:0] older;
        logic [ID_W-1:0] newer;
        older = older_of[f];
        newer = newer_of[f];
        if (held_total <= 1) begin
            newest_frame = '0;
            oldest_frame = '0;
        end
        else begin
            if (f == newest_frame)
                newest_frame = older;
            else
                older_of[newer] = older;
            if (f == oldest_frame)
                oldest_frame = newer;
            else
                newer_of[older] = newer;
        end
        is_held[f] = 1'b0;
        if (held_total > 0)
            held_total--;
    endfunction

    // Apply one operation to the tracker and return the beat it yields
    function automatic rsp_beat_t apply_op(input logic [1:0] o, input logic [ID_W-1:0] f);
        rsp_beat_t       beat;
        logic [ID_W-1:0] v;
        beat = '0;
        case (o)
            lrufr_pkg::OP_VICTIM:
            begin
                if (held_total > 0) begin
                    v = oldest_frame;
                    drop_frame(v);
                    beat.found        = 1'b1;
                    beat.victim_frame = v;
                end
            end
            lrufr_pkg::OP_PIN:
            begin
                if (is_held[f])
                    drop_frame(f);
            end
            lrufr_pkg::OP_UNPIN:
            begin
                if (!is_held[f] && held_total < FRAME_IDS) begin
                    if (held_total == 0) begin
                        newest_frame = f;
                        oldest_frame = f;
                    end
                    else begin
                        older_of[f]            = newest_frame;
                        newer_of[newest_frame] = f;
                        newest_frame           = f;
                    end
                    is_held[f] = 1'b1;
                    held_total++;
                end
            end
            default:
            begin
            end
        endcase
        beat.held_count = held_total[CNT_W-1:0];
        return beat;
    endfunction

    // Send one request beat, with random idle cycles ahead of it
    task automatic drive_req(input logic [1:0] o, input logic [ID_W-1:0] f,
                             input logic typed, input rsp_beat_t typed_beat);
        rsp_beat_t pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= o;
        req.frame <= f;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = apply_op(o, f);
        pending_rsp.push_back(typed ? typed_beat : pred);
        @(negedge clk);
    endtask

    // One burst of random operations; returns how many beats it sent
    task automatic run_burst(output int sent);
        int              mode;
        int              len;
        int              k;
        int              j;
        int              tmp;
        int              r;
        int              base;
        int              order [FRAME_IDS];
        logic [1:0]      o;
        logic [ID_W-1:0] f;
        sent = 0;
        mode = $urandom_range(0, 11);
        base = $urandom_range(0, FRAME_IDS - 8);
        if (mode == 1) begin
            // fill sweep: every frame once in shuffled order, then pushes while full
            for (k = 0; k < FRAME_IDS; k++)
                order[k] = k;
            for (k = FRAME_IDS - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            for (k = 0; k < FRAME_IDS; k++)
                drive_req(lrufr_pkg::OP_UNPIN, order[k][ID_W-1:0], 1'b0, '0);
            for (k = 0; k < 4; k++)
                drive_req(lrufr_pkg::OP_UNPIN, 6'($urandom_range(0, FRAME_IDS - 1)),
                          1'b0, '0);
            sent = FRAME_IDS + 4;
        end
        else begin
            len = (mode == 0) ? 20 : 30;
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                f = 6'($urandom_range(0, FRAME_IDS - 1));
                if (mode == 0) begin
                    // noise, unused code included
                    o = 2'($urandom_range(0, 3));
                end
                else if (mode <= 5) begin
                    // churn on a small working set
                    f = 6'(base + $urandom_range(0, 7));
                    o = (r < 50) ? lrufr_pkg::OP_UNPIN :
                        (r < 80) ? lrufr_pkg::OP_PIN : lrufr_pkg::OP_VICTIM;
                end
                else if (mode <= 8) begin
                    // drain
                    o = (r < 50) ? lrufr_pkg::OP_VICTIM :
                        (r < 90) ? lrufr_pkg::OP_PIN : lrufr_pkg::OP_UNPIN;
                end
                else begin
                    // build up
                    o = (r < 70) ? lrufr_pkg::OP_UNPIN :
                        (r < 85) ? lrufr_pkg::OP_PIN : lrufr_pkg::OP_VICTIM;
                end
                drive_req(o, f, 1'b0, '0);
            end
            sent = len;
        end
    endtask

    // Response ready, changed at the falling edge
    always @(negedge clk)
    begin
        rsp.ready <= rst_n && ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Check each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result beat found %0b victim_frame %0d held_count %0d",
                         $time, rsp.found, rsp.victim_frame, rsp.held_count);
                err_cnt++;
            end
            else begin
                if (rsp.found !== pending_rsp[0].found) begin
                    $display("%0t: found exp %0b got %0b",
                             $time, pending_rsp[0].found, rsp.found);
                    err_cnt++;
                end
                if (rsp.victim_frame !== pending_rsp[0].victim_frame) begin
                    $display("%0t: victim_frame exp %0d got %0d",
                             $time, pending_rsp[0].victim_frame, rsp.victim_frame);
                    err_cnt++;
                end
                if (rsp.held_count !== pending_rsp[0].held_count) begin
                    $display("%0t: held_count exp %0d got %0d",
                             $time, pending_rsp[0].held_count, rsp.held_count);
                    err_cnt++;
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int phase;
        int done;
        int n;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        held_total    = 0;
        newest_frame  = '0;
        oldest_frame  = '0;
        for (int i = 0; i < FRAME_IDS; i++) begin
            older_of[i] = '0;
            newer_of[i] = '0;
            is_held[i]  = 1'b0;
        end
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.op    = lrufr_pkg::OP_VICTIM;
        req.frame = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        for (int i = 0; i < DIR_ROWS; i++)
            drive_req(DIR_TBL[i].op, DIR_TBL[i].frame, DIR_TBL[i].typed, DIR_TBL[i].beat);

        // Random bursts under each idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 55;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct = 15;
                    rsp_stall_pct = 15;
                end
            endcase
            done = 0;
            while (done < PHASE_ITEMS) begin
                run_burst(n);
                done += n;
            end
        end
        req.valid <= 1'b0;

        // Drain, then keep watching for stray beats
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
